// ----- hdl/circq_pkg.sv -----
// ----------------------------------------------------------------------------
// circq_pkg
// Shared types and codes for the circular FIFO queue: request and response
// beats, action and status codes, and the sequencer states.
// ----------------------------------------------------------------------------
package circq_pkg;

   localparam int DEPTH_DEF = 8;
   localparam int OCC_W     = 4;

   localparam logic [1:0] ACT_ENQ  = 2'd0;
   localparam logic [1:0] ACT_DEQ  = 2'd1;
   localparam logic [1:0] ACT_SHOW = 2'd2;

   localparam logic [2:0] ST_STORED     = 3'd0;
   localparam logic [2:0] ST_DEQUEUED   = 3'd1;
   localparam logic [2:0] ST_SHOWN      = 3'd2;
   localparam logic [2:0] ST_FULL       = 3'd3;
   localparam logic [2:0] ST_EMPTY      = 3'd4;
   localparam logic [2:0] ST_EMPTY_SHOW = 3'd5;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] data;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] value;
      logic               last;
      logic [OCC_W-1:0]   occupancy;
   } rsp_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_SHOW
   } seq_state_type;

endpackage

// ----- hdl/circular_fifo_queue_top.sv -----
// ----------------------------------------------------------------------------
// circular_fifo_queue_top
// Circular FIFO of signed 32-bit words held in a synchronous memory, with
// head and tail pointers and an occupancy count; enqueue, dequeue and show.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | req_item : action, data
//  rsp     | out       | rsp_valid / rsp_ready | rsp_item : status, value, last,
//          |           |                       |            occupancy
//
//  Enqueue, dequeue and rejects each give one response beat; a show gives one
//  beat per stored entry, paced by the single memory read port and by rsp_ready.
//  Reset clears pointers, count, sequencer and response valid; the word
//  memory is not cleared, as only written entries are ever read.
//  A stalled response holds in the output register; the next request is
//  taken in the cycle the held beat leaves.
// ----------------------------------------------------------------------------
module circular_fifo_queue_top #(
   parameter int DEPTH = circq_pkg::DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  circq_pkg::req_type req_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output circq_pkg::rsp_type rsp_item
);
   import circq_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] rd_data_ff;

   seq_state_type      state_ff, state_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [PTR_W-1:0]   show_idx_ff, show_idx_in;
   logic [CNT_W-1:0]   show_left_ff, show_left_in;

   logic               rsp_valid_ff;
   logic [2:0]         status_ff, status_in;
   logic               last_ff, last_in;
   logic               use_mem_ff, use_mem_in;
   logic [OCC_W-1:0]   occ_ff;

   logic               out_free;
   logic               load;
   logic               wr_en;
   logic               rd_en;
   logic [PTR_W-1:0]   rd_addr;
   logic               is_empty;
   logic               is_full;
   logic [CNT_W+OCC_W-1:0] occ_wide;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign is_empty = (fill_ff == '0);
   assign is_full  = (fill_ff == CNT_W'(DEPTH));
   assign occ_wide = {{OCC_W{1'b0}}, fill_in};

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      show_idx_in  = show_idx_ff;
      show_left_in = show_left_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      use_mem_in   = use_mem_ff;
      load         = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      req_ready    = 1'b0;
      case (state_ff)
         SEQ_IDLE: begin
            req_ready = out_free;
            if (req_valid && out_free) begin
               case (req_item.action)
                  ACT_ENQ: begin
                     load       = 1'b1;
                     last_in    = 1'b1;
                     use_mem_in = 1'b0;
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        status_in = ST_STORED;
                        wr_en     = 1'b1;
                        tail_in   = next_ptr(tail_ff);
                        fill_in   = fill_ff + CNT_W'(1);
                     end
                  end
                  ACT_DEQ: begin
                     load    = 1'b1;
                     last_in = 1'b1;
                     if (is_empty) begin
                        status_in  = ST_EMPTY;
                        use_mem_in = 1'b0;
                     end else begin
                        status_in  = ST_DEQUEUED;
                        use_mem_in = 1'b1;
                        rd_en      = 1'b1;
                        head_in    = next_ptr(head_ff);
                        fill_in    = fill_ff - CNT_W'(1);
                     end
                  end
                  ACT_SHOW: begin
                     load = 1'b1;
                     if (is_empty) begin
                        status_in  = ST_EMPTY_SHOW;
                        use_mem_in = 1'b0;
                        last_in    = 1'b1;
                     end else begin
                        status_in    = ST_SHOWN;
                        use_mem_in   = 1'b1;
                        rd_en        = 1'b1;
                        last_in      = (fill_ff == CNT_W'(1));
                        show_idx_in  = next_ptr(head_ff);
                        show_left_in = fill_ff - CNT_W'(1);
                        if (fill_ff != CNT_W'(1)) begin
                           state_in = SEQ_SHOW;
                        end
                     end
                  end
                  default: begin
                     // drop unused action code
                  end
               endcase
            end
         end
         SEQ_SHOW: begin
            if (out_free) begin
               load         = 1'b1;
               status_in    = ST_SHOWN;
               use_mem_in   = 1'b1;
               rd_en        = 1'b1;
               rd_addr      = show_idx_ff;
               last_in      = (show_left_ff == CNT_W'(1));
               show_idx_in  = next_ptr(show_idx_ff);
               show_left_in = show_left_ff - CNT_W'(1);
               if (show_left_ff == CNT_W'(1)) begin
                  state_in = SEQ_IDLE;
               end
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= req_item.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         show_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         show_left_ff <= show_left_in;
         rsp_valid_ff <= load || (rsp_valid_ff && !rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      show_idx_ff <= show_idx_in;
      if (load) begin
         status_ff  <= status_in;
         last_ff    <= last_in;
         use_mem_ff <= use_mem_in;
         occ_ff     <= occ_wide[OCC_W-1:0];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_item.status    = status_ff;
   assign rsp_item.value     = use_mem_ff ? rd_data_ff : 32'sd0;
   assign rsp_item.last      = last_ff;
   assign rsp_item.occupancy = occ_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(DEPTH))
      else $error("occupancy count beyond depth");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0 || fill_ff == CNT_W'(DEPTH)) |-> (head_ff == tail_ff))
      else $error("pointers disagree with empty or full count");

   a_ptr_apart: assert property (@(posedge clock) disable iff (reset)
      (fill_ff != '0 && fill_ff != CNT_W'(DEPTH)) |-> (head_ff != tail_ff))
      else $error("pointers meet on a partly filled queue");

   a_show_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_SHOW) |-> (show_left_ff != '0 && show_left_ff < fill_ff))
      else $error("show walk count out of range");

endmodule
